// ===== hdl/sskc_pkg.sv =====
package sskc_pkg;

  // Fixed field widths
  localparam int unsigned SumW   = 24;
  localparam int unsigned ElemW  = 16;
  localparam int unsigned MatchW = 16;

  typedef logic [SumW-1:0]   sum_t;
  typedef logic [ElemW-1:0]  elem_t;
  typedef logic [MatchW-1:0] match_t;

  // Request token handed from cell to cell along the chain
  typedef struct packed {
    logic vld;    // token carries a request
    logic last;   // final element of the array, clears the store behind it
    logic act;    // element is inside the length limit: lookup and insert
    logic ovf;    // array ran past the length limit
    logic found;  // key already matched or claimed by an earlier cell
    sum_t want;   // prefix minus target, looked up
    sum_t key;    // new prefix, inserted or bumped
  } tok_t;

endpackage

// ===== hdl/sskc_head.sv =====
module sskc_head #(
  parameter int unsigned MAX_LEN = 256,
  localparam int unsigned AccW = $clog2(MAX_LEN + 2)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  sskc_pkg::elem_t    elem_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  sskc_pkg::sum_t     cfg_wdata_i,
  output sskc_pkg::tok_t     tok_o,
  output logic [AccW-1:0]    acc_o
);
  import sskc_pkg::*;

  localparam int unsigned EltW = $clog2(MAX_LEN + 1);

  sum_t            target_q;
  sum_t            prefix_q;
  logic [EltW-1:0] elems_q;
  logic            ovf_q;
  logic            vld_q;
  tok_t            tok_q;
  logic [AccW-1:0] acc_q;

  logic accept;
  logic room;
  sum_t sum_nxt;
  sum_t want_nxt;

  assign accept   = in_valid_i && adv_i;
  assign room     = elems_q < EltW'(MAX_LEN);
  assign sum_nxt  = prefix_q + {{(SumW - ElemW){elem_i[ElemW-1]}}, elem_i};
  assign want_nxt = sum_nxt - target_q;

  // Target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // Running prefix, element count and length overflow for the current array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      elems_q  <= '0;
      ovf_q    <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        prefix_q <= '0;
        elems_q  <= '0;
        ovf_q    <= 1'b0;
      end else if (room) begin
        prefix_q <= sum_nxt;
        elems_q  <= elems_q + EltW'(1);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // Token launch; ignored elements enter only when they close the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= accept && (room || last_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q.vld   <= room || last_i;
      tok_q.last  <= last_i;
      tok_q.act   <= room;
      tok_q.ovf   <= ovf_q || !room;
      tok_q.found <= 1'b0;
      tok_q.want  <= want_nxt;
      tok_q.key   <= sum_nxt;
      // the empty prefix counts as one stored zero
      acc_q       <= AccW'(room && (want_nxt == '0));
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end
  assign acc_o = acc_q;

endmodule

// ===== hdl/sskc_cell.sv =====
module sskc_cell #(
  parameter int unsigned MAX_LEN = 256,
  localparam int unsigned AccW = $clog2(MAX_LEN + 2)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  sskc_pkg::tok_t     tok_i,
  input  logic [AccW-1:0]    acc_i,
  output sskc_pkg::tok_t     tok_o,
  output logic [AccW-1:0]    acc_o
);
  import sskc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);

  // One store entry
  logic            valid_q;
  sum_t            key_q;
  logic [CntW-1:0] cnt_q;

  logic            vld_q;
  tok_t            tok_q;
  tok_t            tok_d;
  logic [AccW-1:0] acc_q;

  logic use_tok;
  logic hit_want;
  logic hit_key;
  logic claim;

  assign use_tok  = tok_i.vld && tok_i.act;
  assign hit_want = valid_q && (key_q == tok_i.want);
  assign hit_key  = valid_q && (key_q == tok_i.key);
  // entries fill in order, so the first free cell not yet matched takes the key
  assign claim    = use_tok && !valid_q && !tok_i.found;

  // Entry valid; the closing element clears it on its way past
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      if (tok_i.vld && tok_i.last) begin
        valid_q <= 1'b0;
      end else if (claim) begin
        valid_q <= 1'b1;
      end
    end
  end

  // Entry key and occurrence count
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (claim) begin
        key_q <= tok_i.key;
        cnt_q <= CntW'(1);
      end else if (use_tok && hit_key) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // Hand the request on; lookup uses the count from before this bump
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= tok_i.vld;
    end
  end

  always_comb begin
    tok_d       = tok_i;
    tok_d.found = tok_i.found || (use_tok && (hit_key || claim));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
      acc_q <= acc_i + ((use_tok && hit_want) ? AccW'(cnt_q) : '0);
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end
  assign acc_o = acc_q;

endmodule

// ===== hdl/sskc_tail.sv =====
module sskc_tail #(
  parameter int unsigned MAX_LEN = 256,
  localparam int unsigned AccW = $clog2(MAX_LEN + 2)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               out_ready_i,
  input  sskc_pkg::tok_t     tok_i,
  input  logic [AccW-1:0]    acc_i,
  output logic               valid_o,
  output sskc_pkg::match_t   count_o,
  output logic               ovf_o
);
  import sskc_pkg::*;

  match_t            run_q;
  logic              valid_q;
  match_t            count_q;
  logic              ovf_q;
  logic [MatchW:0]   sum;
  match_t            sat;

  // Saturating add of this element's matches
  assign sum = {1'b0, run_q} + (MatchW + 1)'(acc_i);
  assign sat = sum[MatchW] ? '1 : sum[MatchW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (adv_i && tok_i.vld) begin
      run_q <= tok_i.last ? '0 : sat;
    end
  end

  // Result register; set by a closing element, cleared once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i && tok_i.vld && tok_i.last) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && tok_i.vld && tok_i.last) begin
      count_q <= sat;
      ovf_q   <= tok_i.ovf;
    end
  end

  assign valid_o = valid_q;
  assign count_o = count_q;
  assign ovf_o   = ovf_q;

endmodule

// ===== hdl/subarray_sum_k_counter.sv =====
// Channel   | Direction | tdata                     | tuser      | tlast
// s_axis    | in        | [15:0] element_value      | -          | is_last
// m_axis    | out       | [15:0] match_count        | [0] overflow | -
// cfg       | in        | cfg_wdata_i [23:0] target_sum, written when cfg_we_i
//
// One element enters per cycle while the row advances. A request walks the row
// of MAX_LEN cells, one cell per advancing cycle, on to the tail.
// Reset clears all entry valid bits at once; no clearing pass is needed.
// The whole row, and the input with it, stalls only while a result waits in the
// output register and the next closing element has reached the tail.
module subarray_sum_k_counter #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  sskc_pkg::elem_t      s_axis_tdata_i,   // [15:0] element_value
  input  logic                 s_axis_tlast_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output sskc_pkg::match_t     m_axis_tdata_o,   // [15:0] match_count
  output logic [0:0]           m_axis_tuser_o,   // [0] overflow
  input  logic                 cfg_we_i,
  input  sskc_pkg::sum_t       cfg_wdata_i       // [23:0] target_sum
);
  import sskc_pkg::*;

  localparam int unsigned AccW = $clog2(MAX_LEN + 2);

  tok_t            tok [MAX_LEN+1];
  logic [AccW-1:0] acc [MAX_LEN+1];
  logic            adv;
  logic            out_valid;
  logic            out_ovf;
  logic            out_busy;

  // Row moves unless a new result would land on one still waiting
  assign out_busy        = out_valid && !m_axis_tready_i;
  assign adv             = !(out_busy && tok[MAX_LEN].vld && tok[MAX_LEN].last);
  assign s_axis_tready_o = adv;

  sskc_head #(.MAX_LEN(MAX_LEN)) u_head (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (s_axis_tvalid_i),
    .elem_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tok_o       (tok[0]),
    .acc_o       (acc[0])
  );

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    sskc_cell #(.MAX_LEN(MAX_LEN)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok[g]),
      .acc_i  (acc[g]),
      .tok_o  (tok[g+1]),
      .acc_o  (acc[g+1])
    );
  end

  sskc_tail #(.MAX_LEN(MAX_LEN)) u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .out_ready_i (m_axis_tready_i),
    .tok_i       (tok[MAX_LEN]),
    .acc_i       (acc[MAX_LEN]),
    .valid_o     (out_valid),
    .count_o     (m_axis_tdata_o),
    .ovf_o       (out_ovf)
  );

  assign m_axis_tvalid_o   = out_valid;
  assign m_axis_tuser_o[0] = out_ovf;

endmodule

// ===== hdl/sskc_checker.sv =====
module sskc_checker #(
  parameter int unsigned MAX_LEN = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  // Most subarrays one array of MAX_LEN elements can hold, clipped to 16 bits
  localparam longint Pairs = longint'(MAX_LEN) * (longint'(MAX_LEN) + 1) / 2;
  localparam longint Bound = (Pairs > 65535) ? 65535 : Pairs;

  // Input side stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a held result");

  // No result right after a reset cycle
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result shown during reset");

  // Count never exceeds the subarray total for the length limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o <= 16'(Bound)))
    else $error("match count beyond possible total");

  // Held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind subarray_sum_k_counter sskc_checker #(.MAX_LEN(MAX_LEN)) u_sskc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
